@@ rtl/coverage_union_counter_core_assert.svh @@
// ---------------------------------------------------------------------------
// Coverage union counter assertion macros
// Shared concurrent assertion forms, clocked on clock; one form is held off in reset.
// ---------------------------------------------------------------------------
`ifndef COVERAGE_UNION_COUNTER_CORE_ASSERT_SVH
`define COVERAGE_UNION_COUNTER_CORE_ASSERT_SVH

// Checked property, quiet while reset is high.
`define CUC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property, active through reset as well.
`define CUC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/cuc_pkg.sv @@
// ---------------------------------------------------------------------------
// Coverage union counter package
// Sizes, codes and the command and status bundles shared by the core.
// ---------------------------------------------------------------------------
package cuc_pkg;

   localparam int MAX_TARGETS   = 512;
   localparam int WORD_BITS     = 32;
   localparam int WORDS_PER_ROW = (MAX_TARGETS + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_BITS      = $clog2(MAX_TARGETS);
   localparam int WSEL_BITS     = $clog2(WORDS_PER_ROW);
   localparam int ADDR_BITS     = ROW_BITS + WSEL_BITS;
   localparam int MEM_DEPTH     = MAX_TARGETS * WORDS_PER_ROW;
   localparam int SHIFT_BITS    = $clog2(WORD_BITS);
   localparam int POP_BITS      = $clog2(WORD_BITS + 1);
   localparam int COUNT_BITS    = 10;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Field widths of the request channel.
   localparam int MODE_BITS     = 1;
   localparam int ROW_IDX_BITS  = 9;
   localparam int WORD_IDX_BITS = 4;
   localparam int LOAD_BITS     = 32;

   localparam logic [MODE_BITS-1:0] MODE_LOAD = 1'b0;
   localparam logic [MODE_BITS-1:0] MODE_SITE = 1'b1;

   // Register index as decoded from paddr[2].
   localparam logic CSR_IDX_TARGET_COUNT = 1'b0;

   localparam logic [COUNT_BITS-1:0] TARGET_COUNT_RESET = COUNT_BITS'(MAX_TARGETS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 capture;
      logic                 issue;
      logic [WSEL_BITS-1:0] word_sel;
      logic                 finish;
   } cmd_type;

   typedef struct packed {
      logic req_hit;
      logic pipe_busy;
   } status_type;

endpackage

@@ rtl/coverage_union_counter_core.sv @@
// ---------------------------------------------------------------------------
// Coverage union counter core
// Counts the distinct targets covered together by a set of sites.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   request   start / busy           req_mode, req_row_index, req_word_index,
//                                    req_load_word, req_last_site
//   result    rsp_strobe (1 cycle)   rsp_covered_count
//   config    psel/penable/pwrite    paddr, pwdata, prdata (target_count at 0)
//
// A load request writes one matrix word at its accepting edge and leaves busy low.
// A site request holds busy through a scan of one matrix word read per cycle over
// the row's 16 words on the single memory read port, a drain while the two
// pipeline stages empty into the running count, and a finishing state.
// A site at or beyond the target count skips the scan: drain and finish only.
// The result strobe is registered in the cycle after the last site's finish; the receiver
// cannot stall it. Reset is synchronous; the matrix memory is not cleared.
//
module coverage_union_counter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [cuc_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [cuc_pkg::ROW_IDX_BITS-1:0]  req_row_index,
   input  logic [cuc_pkg::WORD_IDX_BITS-1:0] req_word_index,
   input  logic [cuc_pkg::LOAD_BITS-1:0]     req_load_word,
   input  logic                              req_last_site,
   output logic                              rsp_strobe,
   output logic [cuc_pkg::COUNT_BITS-1:0]    rsp_covered_count,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cuc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [cuc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [cuc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import cuc_pkg::*;

   logic [COUNT_BITS-1:0] eff_count;
   cmd_type               cmd;
   status_type            status;

   cuc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .eff_count (eff_count)
   );

   cuc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   cuc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .eff_count         (eff_count),
      .req_row_index     (req_row_index),
      .req_word_index    (req_word_index),
      .req_load_word     (req_load_word),
      .req_last_site     (req_last_site),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_covered_count (rsp_covered_count)
   );

endmodule

@@ rtl/cuc_regs.sv @@
// ---------------------------------------------------------------------------
// Coverage union counter register block
// APB-style target count register and its clamped working value.
// ---------------------------------------------------------------------------
module cuc_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cuc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [cuc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [cuc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready,
   output logic [cuc_pkg::COUNT_BITS-1:0]    eff_count
);
   import cuc_pkg::*;

   logic [COUNT_BITS-1:0] target_count_ff;
   logic                  wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == CSR_IDX_TARGET_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_count_ff <= TARGET_COUNT_RESET;
      end else if (wr_hit) begin
         target_count_ff <= pwdata[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == CSR_IDX_TARGET_COUNT) begin
         prdata = CSR_DATA_BITS'(target_count_ff);
      end else begin
         prdata = '0;
      end
   end

   // Zero acts as one target; anything past the matrix side acts as the side.
   always_comb begin
      if (target_count_ff == '0) begin
         eff_count = COUNT_BITS'(1);
      end else if (target_count_ff > COUNT_BITS'(MAX_TARGETS)) begin
         eff_count = COUNT_BITS'(MAX_TARGETS);
      end else begin
         eff_count = target_count_ff;
      end
   end

endmodule

@@ rtl/cuc_ctrl.sv @@
// ---------------------------------------------------------------------------
// Coverage union counter controller
// Sequences each request: a load is passed on when accepted; a site runs word scan, pipeline drain and finish.
// ---------------------------------------------------------------------------
`include "coverage_union_counter_core_assert.svh"

module cuc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cuc_pkg::MODE_BITS-1:0] req_mode,
   input  cuc_pkg::status_type           status,
   output logic                          busy,
   output cuc_pkg::cmd_type              cmd
);
   import cuc_pkg::*;

   state_type              state_ff, state_in;
   logic [WSEL_BITS-1:0]   word_ff, word_in;
   logic                   accept;
   logic                   last_word;

   assign accept    = start && (state_ff == ST_IDLE);
   assign last_word = (word_ff == WSEL_BITS'(WORDS_PER_ROW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      word_in  = word_ff;
      case (state_ff)
         ST_IDLE: begin
            word_in = '0;
            if (accept && (req_mode == MODE_SITE)) begin
               // A site outside the target count covers nothing.
               state_in = status.req_hit ? ST_SCAN : ST_DRAIN;
            end
         end
         ST_SCAN: begin
            word_in = word_ff + WSEL_BITS'(1);
            if (last_word) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.word_sel = word_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load    = accept && (req_mode == MODE_LOAD);
            cmd.capture = accept && (req_mode == MODE_SITE);
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   `CUC_ASSERT(a_site_goes_busy, (accept && (req_mode == MODE_SITE)) |=> busy, "site request did not start a scan")
   `CUC_ASSERT(a_finish_after_drain, (state_ff == ST_FINISH) |-> !status.pipe_busy, "finish reached with words still in flight")
   `CUC_ASSERT(a_scan_ends, (state_ff == ST_SCAN && last_word) |=> (state_ff == ST_DRAIN), "word scan overran the row")

endmodule

@@ rtl/cuc_datapath.sv @@
// ---------------------------------------------------------------------------
// Coverage union counter datapath
// Coverage matrix memory, covered mask, fresh-bit count and result register.
// ---------------------------------------------------------------------------
`include "coverage_union_counter_core_assert.svh"

module cuc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  cuc_pkg::cmd_type                  cmd,
   input  logic [cuc_pkg::COUNT_BITS-1:0]    eff_count,
   input  logic [cuc_pkg::ROW_IDX_BITS-1:0]  req_row_index,
   input  logic [cuc_pkg::WORD_IDX_BITS-1:0] req_word_index,
   input  logic [cuc_pkg::LOAD_BITS-1:0]     req_load_word,
   input  logic                              req_last_site,
   output cuc_pkg::status_type               status,
   output logic                              rsp_strobe,
   output logic [cuc_pkg::COUNT_BITS-1:0]    rsp_covered_count
);
   import cuc_pkg::*;

   logic [WORD_BITS-1:0]  mem [MEM_DEPTH];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [WORD_BITS-1:0]  mask_ff [WORDS_PER_ROW];
   logic [ROW_BITS-1:0]   row_ff;
   logic                  last_ff;
   logic                  rd_valid_ff;
   logic [WSEL_BITS-1:0]  rd_word_ff;
   logic                  cnt_valid_ff;
   logic [POP_BITS-1:0]   cnt_ff;
   logic [COUNT_BITS-1:0] running_ff, running_in;
   logic                  strobe_ff;
   logic [COUNT_BITS-1:0] result_ff;

   logic                  load_ok;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [COUNT_BITS-1:0] base;
   logic [COUNT_BITS-1:0] rem;
   logic [WORD_BITS-1:0]  limit;
   logic [WORD_BITS-1:0]  fresh;

   assign load_ok = cmd.load && (32'(req_row_index) < MAX_TARGETS)
                    && (32'(req_word_index) < WORDS_PER_ROW);
   assign wr_addr = {req_row_index[ROW_BITS-1:0], req_word_index[WSEL_BITS-1:0]};
   assign rd_addr = {row_ff, cmd.word_sel};

   always_ff @(posedge clock) begin
      if (load_ok) begin
         mem[wr_addr] <= req_load_word[WORD_BITS-1:0];
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff  <= req_row_index[ROW_BITS-1:0];
         last_ff <= req_last_site;
      end
      if (cmd.issue) begin
         rd_word_ff <= cmd.word_sel;
      end
      if (rd_valid_ff) begin
         cnt_ff <= POP_BITS'($countones(fresh));
      end
   end

   // Only targets below the working count take part.
   always_comb begin
      base = COUNT_BITS'(rd_word_ff) << SHIFT_BITS;
      rem  = eff_count - base;
      if (eff_count <= base) begin
         limit = '0;
      end else if (rem >= COUNT_BITS'(WORD_BITS)) begin
         limit = '1;
      end else begin
         limit = ~({WORD_BITS{1'b1}} << rem[SHIFT_BITS-1:0]);
      end
      fresh = rd_data_ff & limit & ~mask_ff[rd_word_ff];
   end

   always_comb begin
      running_in = running_ff;
      if (cnt_valid_ff) begin
         running_in = running_ff + COUNT_BITS'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         cnt_valid_ff <= 1'b0;
         running_ff   <= '0;
         strobe_ff    <= 1'b0;
         for (int i = 0; i < WORDS_PER_ROW; i++) begin
            mask_ff[i] <= '0;
         end
      end else begin
         rd_valid_ff  <= cmd.issue;
         cnt_valid_ff <= rd_valid_ff;
         strobe_ff    <= cmd.finish && last_ff;
         if (cmd.finish && last_ff) begin
            running_ff <= '0;
            for (int i = 0; i < WORDS_PER_ROW; i++) begin
               mask_ff[i] <= '0;
            end
         end else begin
            running_ff <= running_in;
            if (rd_valid_ff) begin
               mask_ff[rd_word_ff] <= mask_ff[rd_word_ff] | fresh;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         result_ff <= running_ff;
      end
   end

   assign status.req_hit   = COUNT_BITS'(req_row_index) < eff_count;
   assign status.pipe_busy = rd_valid_ff || cnt_valid_ff;

   assign rsp_strobe        = strobe_ff;
   assign rsp_covered_count = result_ff;

   `CUC_ASSERT(a_strobe_single, rsp_strobe |=> !rsp_strobe, "result strobe held for two cycles")
   `CUC_ASSERT(a_strobe_after_finish, rsp_strobe |-> $past(cmd.finish), "result strobe without a finishing site")
   `CUC_ASSERT_ALWAYS(a_count_follows_read, cnt_valid_ff |-> $past(rd_valid_ff), "fresh count without a matrix read")

endmodule

@@ verif/coverage_union_counter_core_tb.sv @@
// ---------------------------------------------------------------------------
// Coverage union counter core testbench
// Loads coverage rows, sends site requests in sets and compares each covered
// count with a model of the union count or a pinned value; target_count is swept
// through its extremes between phases, with the request side idling at varying rates.
// ---------------------------------------------------------------------------
module coverage_union_counter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cuc_pkg::*;

   localparam int DRAIN_CYCLES    = 30;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int PHASE_ITEMS     = 150;
   localparam int N_PHASES        = 8;
   localparam int ROW_POOL        = 48;

   typedef enum logic [1:0] {
      STEP_LOAD,
      STEP_FILL,
      STEP_SITE,
      STEP_TARGETS
   } step_kind_type;

   typedef struct packed {
      step_kind_type             kind;
      logic [ROW_IDX_BITS-1:0]   row;
      logic [WORD_IDX_BITS-1:0]  word;
      logic [LOAD_BITS-1:0]      data;
      logic                      last;
      logic                      pinned;
      logic [COUNT_BITS-1:0]     pinned_count;
   } step_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [MODE_BITS-1:0]      req_mode = MODE_LOAD;
   logic [ROW_IDX_BITS-1:0]   req_row_index = '0;
   logic [WORD_IDX_BITS-1:0]  req_word_index = '0;
   logic [LOAD_BITS-1:0]      req_load_word = '0;
   logic                      req_last_site = 1'b0;
   logic                      rsp_strobe;
   logic [COUNT_BITS-1:0]     rsp_covered_count;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  paddr = '0;
   logic [CSR_DATA_BITS-1:0]  pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  prdata;
   logic                      pready;

   // Union count model state.
   logic [WORD_BITS-1:0]      coverage_matrix [MAX_TARGETS][WORDS_PER_ROW];
   logic [WORDS_PER_ROW-1:0]  row_written [MAX_TARGETS];
   logic [WORD_BITS-1:0]      covered_bits [WORDS_PER_ROW];
   int unsigned               distinct_total;
   logic [COUNT_BITS-1:0]     target_limit;

   logic [COUNT_BITS-1:0]     expected_counts [$];
   logic [COUNT_BITS-1:0]     count_wanted;
   int                        error_count = 0;
   int                        idle_pct = 0;
   int                        quiet_cycles = 0;

   logic [COUNT_BITS-1:0] targets_plan [N_PHASES] =
      '{10'd5, 10'd33, 10'd0, 10'd64, 10'd1023, 10'd512, 10'd17, 10'd2};
   int idle_plan [N_PHASES] = '{0, 72, 13, 0, 72, 13, 72, 0};

   // Target count starts at 512 after reset.
   step_type directed_steps [0:27] = '{
      '{STEP_FILL,    9'd0,   4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
      '{STEP_FILL,    9'd1,   4'd0,  32'h0000_0000, 1'b0, 1'b0, 10'd0},
      '{STEP_FILL,    9'd511, 4'd0,  32'hAAAA_AAAA, 1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd0,   4'd0,  32'h0,         1'b1, 1'b1, 10'd512},
      '{STEP_SITE,    9'd1,   4'd0,  32'h0,         1'b1, 1'b1, 10'd0},
      '{STEP_SITE,    9'd511, 4'd0,  32'h0,         1'b1, 1'b1, 10'd256},
      '{STEP_SITE,    9'd0,   4'd0,  32'h0,         1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd0,   4'd0,  32'h0,         1'b1, 1'b1, 10'd512},
      '{STEP_LOAD,    9'd1,   4'd15, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd1,   4'd0,  32'h0,         1'b1, 1'b1, 10'd1},
      // A load that lands inside an open set is seen by the next site.
      '{STEP_SITE,    9'd1,   4'd0,  32'h0,         1'b0, 1'b0, 10'd0},
      '{STEP_LOAD,    9'd1,   4'd0,  32'h0000_0001, 1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd1,   4'd0,  32'h0,         1'b1, 1'b1, 10'd2},
      '{STEP_TARGETS, 9'd0,   4'd0,  32'd0,         1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd0,   4'd0,  32'h0,         1'b1, 1'b1, 10'd1},
      '{STEP_SITE,    9'd1,   4'd0,  32'h0,         1'b1, 1'b1, 10'd0},
      '{STEP_TARGETS, 9'd0,   4'd0,  32'd1023,      1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd511, 4'd0,  32'h0,         1'b1, 1'b1, 10'd256},
      '{STEP_TARGETS, 9'd0,   4'd0,  32'd33,        1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd0,   4'd0,  32'h0,         1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd511, 4'd0,  32'h0,         1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd1,   4'd0,  32'h0,         1'b1, 1'b1, 10'd33},
      '{STEP_SITE,    9'd511, 4'd0,  32'h0,         1'b1, 1'b1, 10'd0},
      '{STEP_TARGETS, 9'd0,   4'd0,  32'd32,        1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd0,   4'd0,  32'h0,         1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd1,   4'd0,  32'h0,         1'b1, 1'b0, 10'd0},
      '{STEP_TARGETS, 9'd0,   4'd0,  32'd1,         1'b0, 1'b0, 10'd0},
      '{STEP_SITE,    9'd0,   4'd0,  32'h0,         1'b1, 1'b1, 10'd1}
   };

   coverage_union_counter_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_row_index     (req_row_index),
      .req_word_index    (req_word_index),
      .req_load_word     (req_load_word),
      .req_last_site     (req_last_site),
      .rsp_strobe        (rsp_strobe),
      .rsp_covered_count (rsp_covered_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned clamped_limit();
      if (target_limit == 0)
         return 1;
      if (target_limit > MAX_TARGETS)
         return MAX_TARGETS;
      return target_limit;
   endfunction

   // Applies one request to the model; returns 1 when it closes a set.
   function automatic bit predict_union(input logic [MODE_BITS-1:0] mode,
                                        input logic [ROW_IDX_BITS-1:0] row,
                                        input logic [WORD_IDX_BITS-1:0] word,
                                        input logic [LOAD_BITS-1:0] data,
                                        input logic last,
                                        output logic [COUNT_BITS-1:0] count);
      int unsigned          limit;
      int unsigned          base;
      logic [WORD_BITS-1:0] in_range;
      logic [WORD_BITS-1:0] fresh;
      count = '0;
      if (mode == MODE_LOAD) begin
         coverage_matrix[row][word] = data;
         row_written[row][word] = 1'b1;
         return 1'b0;
      end
      limit = clamped_limit();
      if (row < limit) begin
         for (int w = 0; w < WORDS_PER_ROW; w++) begin
            base = w * WORD_BITS;
            if (base >= limit)
               in_range = '0;
            else if (limit - base >= WORD_BITS)
               in_range = '1;
            else
               in_range = (WORD_BITS'(1) << (limit - base)) - 1'b1;
            fresh = coverage_matrix[row][w] & in_range & ~covered_bits[w];
            covered_bits[w] |= fresh;
            distinct_total += $countones(fresh);
         end
      end
      if (!last)
         return 1'b0;
      count = COUNT_BITS'(distinct_total);
      foreach (covered_bits[w])
         covered_bits[w] = '0;
      distinct_total = 0;
      return 1'b1;
   endfunction

   function automatic logic [LOAD_BITS-1:0] pattern_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return $urandom() & $urandom() & $urandom();
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(input logic [MODE_BITS-1:0] mode,
                               input logic [ROW_IDX_BITS-1:0] row,
                               input logic [WORD_IDX_BITS-1:0] word,
                               input logic [LOAD_BITS-1:0] data,
                               input logic last,
                               input logic pinned,
                               input logic [COUNT_BITS-1:0] pinned_count);
      logic [COUNT_BITS-1:0] count;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= mode;
      req_row_index  <= row;
      req_word_index <= word;
      req_load_word  <= data;
      req_last_site  <= last;
      do
         @(posedge clock);
      while (busy);
      if (predict_union(mode, row, word, data, last, count))
         expected_counts.push_back(pinned ? pinned_count : count);
   endtask

   // Waits until every closed set has reported and the scan pipeline is empty.
   task automatic settle();
      start <= 1'b0;
      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_target_count(input logic [COUNT_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [CSR_DATA_BITS-1:0] want;
      wdata = $urandom();
      wdata[COUNT_BITS-1:0] = value;
      want = CSR_DATA_BITS'(value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_IDX_TARGET_COUNT, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      target_limit = value;
      // Read the register straight back.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      if (prdata !== want) begin
         $display("%0t: target_count readback expected %0d actual %0d", $time, want, prdata);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_random_phase(input int unsigned quota);
      int unsigned sent;
      int unsigned limit;
      int unsigned sites;
      int unsigned pick;
      int unsigned row;
      sent = 0;
      limit = clamped_limit();
      while (sent < quota) begin
         sites = $urandom_range(1, 5);
         for (int s = 0; s < sites; s++) begin
            pick = $urandom_range(99);
            if (pick < 10 && limit < MAX_TARGETS)
               row = $urandom_range(MAX_TARGETS - 1, limit);
            else if (pick < 14)
               row = $urandom_range(MAX_TARGETS - 1, 0);
            else
               row = $urandom_range(((limit > ROW_POOL) ? ROW_POOL : limit) - 1, 0);
            // A site inside the target count scans its whole row, so every
            // word of it must hold loaded data first.
            if (row < limit) begin
               for (int w = 0; w < WORDS_PER_ROW; w++) begin
                  if (!row_written[row][w]) begin
                     send_request(MODE_LOAD, ROW_IDX_BITS'(row), WORD_IDX_BITS'(w),
                                  pattern_word(), 1'($urandom()), 1'b0, '0);
                     sent++;
                  end
               end
            end
            if ($urandom_range(99) < 15) begin
               send_request(MODE_LOAD, ROW_IDX_BITS'($urandom()), WORD_IDX_BITS'($urandom()),
                            pattern_word(), 1'($urandom()), 1'b0, '0);
               sent++;
            end
            send_request(MODE_SITE, ROW_IDX_BITS'(row), WORD_IDX_BITS'($urandom()),
                         LOAD_BITS'($urandom()), s == sites - 1, 1'b0, '0);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: covered count expected none actual %0d", $time, rsp_covered_count);
            error_count++;
         end else begin
            count_wanted = expected_counts.pop_front();
            if (rsp_covered_count !== count_wanted) begin
               $display("%0t: covered count expected %0d actual %0d",
                        $time, count_wanted, rsp_covered_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      foreach (row_written[r])
         row_written[r] = '0;
      foreach (covered_bits[w])
         covered_bits[w] = '0;
      distinct_total = 0;
      target_limit = TARGET_COUNT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            STEP_LOAD: begin
               send_request(MODE_LOAD, directed_steps[i].row, directed_steps[i].word,
                            directed_steps[i].data, 1'b0, 1'b0, '0);
            end
            STEP_FILL: begin
               for (int w = 0; w < WORDS_PER_ROW; w++)
                  send_request(MODE_LOAD, directed_steps[i].row, WORD_IDX_BITS'(w),
                               directed_steps[i].data, 1'b0, 1'b0, '0);
            end
            STEP_SITE: begin
               send_request(MODE_SITE, directed_steps[i].row, '0, '0,
                            directed_steps[i].last, directed_steps[i].pinned,
                            directed_steps[i].pinned_count);
            end
            default: begin
               settle();
               write_target_count(directed_steps[i].data[COUNT_BITS-1:0]);
            end
         endcase
      end

      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         write_target_count(targets_plan[p]);
         idle_pct = idle_plan[p];
         run_random_phase(PHASE_ITEMS);
      end

      settle();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cuc_pkg.sv
rtl/cuc_regs.sv
rtl/cuc_ctrl.sv
rtl/cuc_datapath.sv
rtl/coverage_union_counter_core.sv
verif/coverage_union_counter_core_tb.sv
